@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files of the extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/lsbx_pkg.sv @@
// Types and constants shared by the extractor modules.
package lsbx_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEADER_LENGTH = 2'd0;
    localparam logic [1:0] CFG_MAGIC_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_MAGIC_VALUE   = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  HEADER_LENGTH_RST = 8'd54;
    localparam logic [3:0]  MAGIC_LENGTH_RST  = 4'd2;
    localparam logic [63:0] MAGIC_VALUE_RST   = 64'd0;

    // Bit position of the last bit of the payload size.
    localparam logic [5:0] SIZE_LAST_BIT = 6'd63;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_EXT      = 2'd0,
        KIND_SIZE     = 2'd1,
        KIND_PAYLOAD  = 2'd2,
        KIND_MISMATCH = 2'd3
    } kind_t;

    // Frame phases, one-hot.
    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_MAGIC   = 8'b0000_0010,
        PH_EXTLEN  = 8'b0000_0100,
        PH_EXT     = 8'b0000_1000,
        PH_SIZE    = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_HALT    = 8'b1000_0000
    } phase_t;

    // Live configuration registers.
    typedef struct packed {
        logic [7:0]  header_length;
        logic [3:0]  magic_length;
        logic [63:0] magic_value;
    } cfg_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [63:0] size;
        logic        last;
    } result_t;

    // Outcome of one parser step.
    typedef struct packed {
        logic    emit;
        result_t res;
    } step_t;

endpackage

@@ hw/rtl/lsbx_if.sv @@
// Valid/ready channel interfaces for cover bytes and result items.
interface lsbx_cover_if;
    logic       valid;
    logic       ready;
    logic [7:0] cover_byte;

    modport source (output valid, output cover_byte, input ready);
    modport sink (input valid, input cover_byte, output ready);
endinterface

interface lsbx_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [63:0] out_size;
    logic        out_last;

    modport source (output valid, output out_kind, output out_byte, output out_size,
                    output out_last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input out_size,
                  input out_last, output ready);
endinterface

@@ hw/rtl/lsb_stego_payload_extractor.sv @@
// Top level of the hidden payload extractor for LSB-coded cover images.
//
//  Channel   Direction  Contents
//  image     in         cover_byte, one image byte per request
//  result    out        out_kind, out_byte, out_size, out_last
//  cfg_*     in         write port for header_length, magic_length, magic_value
//
// One cover byte is taken every cycle while the input register is free; a request is held
// in the input register, and its result is loaded into the result register as it leaves.
// The frame state updates in a single step per bit, so one byte per cycle is kept
// up as long as the result register drains.
// Cover bytes that yield no result pass even while a result waits; a byte that
// yields one waits in the input register until the result register is free.
// Reset clears all frame state and loads the register reset values at once.
`include "assert_macros.svh"

module lsb_stego_payload_extractor
#(
    parameter int MAGIC_MAX_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    lsbx_cover_if.sink  image,
    lsbx_result_if.source result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import lsbx_pkg::*;

    cfg_t  cfg_reg;
    step_t step;
    logic  in_vld;
    logic  in_bit;
    logic  out_free;
    logic  advance;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_length <= HEADER_LENGTH_RST;
            cfg_reg.magic_length  <= MAGIC_LENGTH_RST;
            cfg_reg.magic_value   <= MAGIC_VALUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_LENGTH: cfg_reg.header_length <= cfg_data[7:0];
                CFG_MAGIC_LENGTH:  cfg_reg.magic_length  <= cfg_data[3:0];
                CFG_MAGIC_VALUE:   cfg_reg.magic_value   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A bit moves on unless it makes a result that has nowhere to go.
    assign advance = in_vld && (!step.emit || out_free);

    lsbx_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .image   (image),
        .advance (advance),
        .in_vld  (in_vld),
        .in_bit  (in_bit)
    );

    lsbx_parser #(
        .MAGIC_MAX_BYTES (MAGIC_MAX_BYTES)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_bit  (in_bit),
        .advance (advance),
        .step    (step)
    );

    lsbx_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .advance  (advance),
        .out_free (out_free),
        .result   (result)
    );

    // Input stalls only behind a result the sink has not taken.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !image.ready, result.valid && !result.ready, "input stalled without a blocked result")
    // A result produced by the parser shows up on the next cycle.
    `ASSERT_NEXT(a_result_shown, clk, rst_n, advance && step.emit, result.valid, "parser result was not presented")
    // Only a size announcement carries a size.
    `ASSERT_IMPLIES(a_size_kind, clk, rst_n, result.valid && result.out_kind != KIND_SIZE, result.out_size == 64'd0, "size set on a non-size result")
    // A mismatch ends the frame and carries no byte.
    `ASSERT_IMPLIES(a_mismatch_last, clk, rst_n, result.valid && result.out_kind == KIND_MISMATCH, result.out_last && result.out_byte == 8'd0, "malformed mismatch result")
endmodule

@@ hw/rtl/lsbx_in_stage.sv @@
// Input register that holds the hidden bit of one cover byte.
module lsbx_in_stage
(
    input  logic clk,
    input  logic rst_n,
    lsbx_cover_if.sink image,
    input  logic advance,
    output logic in_vld,
    output logic in_bit
);
    logic vld_reg;
    logic vld_next;
    logic bit_reg;

    // The register is free when empty or when its request moves on this cycle.
    assign image.ready = !vld_reg || advance;
    assign in_vld      = vld_reg;
    assign in_bit      = bit_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (image.valid && image.ready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Only bit 0 of a cover byte carries hidden data.
    always_ff @(posedge clk)
    begin
        if (image.valid && image.ready)
        begin
            bit_reg <= image.cover_byte[0];
        end
    end
endmodule

@@ hw/rtl/lsbx_parser.sv @@
// Frame parser: header skip, magic check, extension, size and payload.
module lsbx_parser
#(
    parameter int MAGIC_MAX_BYTES = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  lsbx_pkg::cfg_t  cfg,
    input  logic            in_bit,
    input  logic            advance,
    output lsbx_pkg::step_t step
);
    import lsbx_pkg::*;

    localparam int MAGIC_CAP = (MAGIC_MAX_BYTES > 8) ? 8 : MAGIC_MAX_BYTES;
    localparam int MIW       = $clog2(MAGIC_CAP + 1);

    phase_t         phase_reg, phase_next;
    logic [7:0]     header_count_reg, header_count_next;
    logic [5:0]     bit_index_reg, bit_index_next;
    logic [7:0]     acc_reg, acc_next;
    logic [MIW-1:0] magic_index_reg, magic_index_next;
    logic           magic_bad_reg, magic_bad_next;
    logic [7:0]     ext_rem_reg, ext_rem_next;
    logic [63:0]    size_shift_reg, size_shift_next;
    logic [63:0]    payload_rem_reg, payload_rem_next;

    logic [MIW-1:0] magic_len_eff;
    logic [MIW-1:0] magic_index_inc;
    logic [3:0]     magic_sel;
    logic [7:0]     magic_want;
    logic [7:0]     full_byte;
    logic           byte_done;
    logic           magic_bad;
    logic [7:0]     ext_rem_dec;
    logic [63:0]    size_full;
    logic [63:0]    payload_rem_dec;
    phase_t         eff_phase;
    logic           skip;

    // Magic length clamped to the supported maximum.
    assign magic_len_eff = (cfg.magic_length > 4'(MAGIC_CAP)) ? MIW'(MAGIC_CAP)
                                                              : MIW'(cfg.magic_length);

    // Expected magic byte for the current index.
    assign magic_sel  = 4'(magic_index_reg);
    assign magic_want = cfg.magic_value[{magic_sel[2:0], 3'b000} +: 8];

    // Byte assembly, least significant bit first.
    assign full_byte       = acc_reg | (8'(in_bit) << bit_index_reg[2:0]);
    assign byte_done       = (bit_index_reg[2:0] == 3'd7);
    assign magic_index_inc = magic_index_reg + MIW'(1);
    assign magic_bad       = magic_bad_reg || (full_byte != magic_want);
    assign ext_rem_dec     = ext_rem_reg - 8'd1;
    assign size_full       = size_shift_reg | (64'(in_bit) << bit_index_reg);
    assign payload_rem_dec = payload_rem_reg - 64'd1;

    // Next state and result for the bit held in the input register.
    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_index_next    = bit_index_reg;
        acc_next          = acc_reg;
        magic_index_next  = magic_index_reg;
        magic_bad_next    = magic_bad_reg;
        ext_rem_next      = ext_rem_reg;
        size_shift_next   = size_shift_reg;
        payload_rem_next  = payload_rem_reg;
        step              = '0;
        eff_phase         = phase_reg;
        skip              = 1'b0;

        // Header bytes are dropped; once the header is over the bit goes to the frame.
        if (phase_reg == PH_HEADER)
        begin
            if (header_count_reg < cfg.header_length)
            begin
                header_count_next = header_count_reg + 8'd1;
                skip              = 1'b1;
            end
            else
            begin
                eff_phase = PH_MAGIC;
            end
        end
        if (eff_phase == PH_MAGIC && magic_index_reg >= magic_len_eff)
        begin
            eff_phase = PH_EXTLEN;
        end
        phase_next = eff_phase;

        // Shared byte collector for the byte-wide phases.
        if (eff_phase == PH_MAGIC || eff_phase == PH_EXTLEN || eff_phase == PH_EXT
            || eff_phase == PH_PAYLOAD)
        begin
            if (byte_done)
            begin
                acc_next       = 8'd0;
                bit_index_next = 6'd0;
            end
            else
            begin
                acc_next       = full_byte;
                bit_index_next = bit_index_reg + 6'd1;
            end
        end

        if (!skip)
        begin
            unique case (eff_phase)
                PH_MAGIC:
                begin
                    if (byte_done)
                    begin
                        magic_bad_next   = magic_bad;
                        magic_index_next = magic_index_inc;
                        if (magic_index_inc >= magic_len_eff)
                        begin
                            if (magic_bad)
                            begin
                                phase_next    = PH_HALT;
                                step.emit     = 1'b1;
                                step.res.kind = KIND_MISMATCH;
                                step.res.last = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_EXTLEN;
                            end
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    if (byte_done)
                    begin
                        ext_rem_next    = full_byte;
                        phase_next      = (full_byte == 8'd0) ? PH_SIZE : PH_EXT;
                        size_shift_next = 64'd0;
                    end
                end
                PH_EXT:
                begin
                    if (byte_done)
                    begin
                        ext_rem_next = ext_rem_dec;
                        if (ext_rem_dec == 8'd0)
                        begin
                            phase_next      = PH_SIZE;
                            size_shift_next = 64'd0;
                        end
                        step.emit     = 1'b1;
                        step.res.kind = KIND_EXT;
                        step.res.data = full_byte;
                    end
                end
                PH_SIZE:
                begin
                    size_shift_next = size_full;
                    if (bit_index_reg != SIZE_LAST_BIT)
                    begin
                        bit_index_next = bit_index_reg + 6'd1;
                    end
                    else
                    begin
                        bit_index_next   = 6'd0;
                        payload_rem_next = size_full;
                        phase_next       = (size_full == 64'd0) ? PH_DONE : PH_PAYLOAD;
                        step.emit        = 1'b1;
                        step.res.kind    = KIND_SIZE;
                        step.res.size    = size_full;
                        step.res.last    = (size_full == 64'd0);
                    end
                end
                PH_PAYLOAD:
                begin
                    if (byte_done)
                    begin
                        payload_rem_next = payload_rem_dec;
                        if (payload_rem_dec == 64'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        step.emit     = 1'b1;
                        step.res.kind = KIND_PAYLOAD;
                        step.res.data = full_byte;
                        step.res.last = (payload_rem_dec == 64'd0);
                    end
                end
                default:
                begin
                    // Header, finished or halted: the bit is dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 8'd0;
            bit_index_reg    <= 6'd0;
            acc_reg          <= 8'd0;
            magic_index_reg  <= '0;
            magic_bad_reg    <= 1'b0;
            ext_rem_reg      <= 8'd0;
            size_shift_reg   <= 64'd0;
            payload_rem_reg  <= 64'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_index_reg    <= bit_index_next;
            acc_reg          <= acc_next;
            magic_index_reg  <= magic_index_next;
            magic_bad_reg    <= magic_bad_next;
            ext_rem_reg      <= ext_rem_next;
            size_shift_reg   <= size_shift_next;
            payload_rem_reg  <= payload_rem_next;
        end
    end
endmodule

@@ hw/rtl/lsbx_out_stage.sv @@
// Result register that holds one result until the sink takes it.
module lsbx_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  lsbx_pkg::step_t step,
    input  logic            advance,
    output logic            out_free,
    lsbx_result_if.source   result
);
    import lsbx_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;
    logic    load;

    assign out_free = !vld_reg || result.ready;
    assign load     = advance && step.emit;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload is loaded only when a new result comes in.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= step.res;
        end
    end

    assign result.valid    = vld_reg;
    assign result.out_kind = res_reg.kind;
    assign result.out_byte = res_reg.data;
    assign result.out_size = res_reg.size;
    assign result.out_last = res_reg.last;
endmodule
